[rtl/brf_pkg.sv]
// Shared types, bank codes and the mode-to-bank table for the banked register file.
package brf_pkg;

	localparam int NUM_BANKS     = 7;
	localparam int REGS_PER_BANK = 16;
	localparam int STORE_DEPTH   = NUM_BANKS * REGS_PER_BANK;
	localparam int STORE_AW      = 7;

	localparam logic [2:0] BANK_USER  = 3'd0;
	localparam logic [2:0] BANK_FIQ   = 3'd1;
	localparam logic [2:0] BANK_IRQ   = 3'd2;
	localparam logic [2:0] BANK_SVC   = 3'd3;
	localparam logic [2:0] BANK_ABT   = 3'd4;
	localparam logic [2:0] BANK_UND   = 3'd5;
	localparam logic [2:0] BANK_DUMMY = 3'd6;

	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_SWITCH = 2'd2;

	localparam logic [4:0] MODE_SVC = 5'd19;

	localparam logic [3:0] R8  = 4'd8;
	localparam logic [3:0] R13 = 4'd13;
	localparam logic [3:0] R14 = 4'd14;

	// controller to datapath
	typedef struct packed {
		logic                load;
		logic                access;
		logic                step;
		logic [3:0]          step_reg;
		logic                clear;
		logic [STORE_AW-1:0] clear_addr;
		logic                finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       bank_change;
		logic       out_free;
	} sts_t;

	function automatic logic [2:0] mode_bank(input logic [4:0] m);
		logic [2:0] b;
		case (m)
			5'd0, 5'd16, 5'd31: b = BANK_USER;
			5'd1, 5'd17:        b = BANK_FIQ;
			5'd2, 5'd18:        b = BANK_IRQ;
			5'd3, 5'd19:        b = BANK_SVC;
			5'd23:              b = BANK_ABT;
			5'd27:              b = BANK_UND;
			default:            b = BANK_DUMMY;
		endcase
		return b;
	endfunction

	// store word address: bank * 16 + reg
	function automatic logic [STORE_AW-1:0] store_addr(input logic [2:0] bank,
		input logic [3:0] r);
		return {bank, r};
	endfunction

endpackage

[rtl/brf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 112
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/brf_ctrl.sv]
// Sequencer for the banked register file: clearing pass, access and mode-switch steps.
module brf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  brf_pkg::sts_t sts,
	output brf_pkg::cmd_t cmd
);
	import brf_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_SWITCH = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [3:0]          step_q, step_d;
	logic [STORE_AW-1:0] clr_q, clr_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		clr_d   = clr_q;
		cmd     = '0;
		cmd.step_reg   = step_q;
		cmd.clear_addr = clr_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				clr_d     = clr_q + 1'b1;
				if (clr_q == STORE_AW'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				if (sts.op == OP_SWITCH && sts.bank_change) begin
					step_d  = R8;
					state_d = ST_SWITCH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SWITCH: begin
				cmd.step = 1'b1;
				step_d   = step_q + 1'b1;
				if (step_q == R14) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= R8;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			clr_q   <= clr_d;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cmd.step_reg >= R8 && cmd.step_reg <= R14))
		else $error("switch step outside r8..r14");

	a_no_load_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !cmd.load)
		else $error("beat taken during clearing pass");

	a_load_then_access: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_ACCESS))
		else $error("accepted beat not followed by access");

endmodule

[rtl/brf_dpath.sv]
// Datapath: active registers, bank store, item and result registers.
module brf_dpath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  brf_pkg::cmd_t cmd,
	output brf_pkg::sts_t sts,
	input  logic [1:0]    mode,
	input  logic [4:0]    cpu_mode,
	input  logic [3:0]    reg_index,
	input  logic [31:0]   write_value,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   read_data,
	output logic [4:0]    active_mode
);
	import brf_pkg::*;

	// item registers
	logic [1:0]            op_q;
	logic [4:0]            cmode_q;
	logic [3:0]            reg_q;
	logic [DATA_WIDTH-1:0] wval_q;

	logic [4:0]            cur_mode_q;
	logic [DATA_WIDTH-1:0] active_q [REGS_PER_BANK];

	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  from_ram_q;

	// restore write, applied in the cycle after the switch step that requested it
	logic                  pend_s1;
	logic                  pend_zero_s1;
	logic [3:0]            pend_idx_s1;

	logic                  out_valid_q;
	logic [31:0]           read_data_q;
	logic [4:0]            active_mode_q;

	logic [2:0]            old_bank, new_bank;
	logic                  same_mode;
	logic                  hi_reg;
	logic [DATA_WIDTH+31:0] wval_wide;
	logic [DATA_WIDTH+31:0] rd_wide;
	logic [DATA_WIDTH-1:0] res_data;

	logic                  ram_we, ram_re;
	logic [STORE_AW-1:0]   ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	logic [3:0]            act_ridx;
	logic [DATA_WIDTH-1:0] act_rdata;
	logic                  act_we;
	logic [3:0]            act_widx;
	logic [DATA_WIDTH-1:0] act_wdata;

	logic                  pend_d, pend_zero_d;

	assign old_bank  = mode_bank(cur_mode_q);
	assign new_bank  = mode_bank(cmode_q);
	assign same_mode = (cmode_q == cur_mode_q);
	assign hi_reg    = (cmd.step_reg >= R13);
	assign wval_wide = {{DATA_WIDTH{1'b0}}, write_value};

	assign act_ridx  = cmd.step ? cmd.step_reg : reg_q;
	assign act_rdata = active_q[act_ridx];

	assign sts.op          = op_q;
	assign sts.bank_change = (old_bank != new_bank);
	assign sts.out_free    = !out_valid_q || !out_stall;

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;
		act_we      = 1'b0;
		act_widx    = pend_idx_s1;
		act_wdata   = pend_zero_s1 ? '0 : ram_rdata;
		pend_d      = 1'b0;
		pend_zero_d = 1'b0;

		if (pend_s1) begin
			act_we = 1'b1;
		end

		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = cmd.clear_addr;
		end

		if (cmd.access && !same_mode) begin
			if (op_q == OP_READ) begin
				ram_re    = 1'b1;
				ram_raddr = store_addr(new_bank, reg_q);
			end else if (op_q == OP_WRITE) begin
				ram_we    = 1'b1;
				ram_waddr = store_addr(new_bank, reg_q);
				ram_wdata = wval_q;
			end
		end
		if (cmd.access && same_mode && op_q == OP_WRITE) begin
			act_we    = 1'b1;
			act_widx  = reg_q;
			act_wdata = wval_q;
		end

		if (cmd.step) begin
			// save side
			if (old_bank == BANK_FIQ) begin
				ram_we    = 1'b1;
				ram_waddr = store_addr(BANK_FIQ, cmd.step_reg);
				ram_wdata = act_rdata;
			end else if (old_bank == BANK_DUMMY) begin
				ram_we    = 1'b1;
				ram_waddr = store_addr(BANK_DUMMY, cmd.step_reg);
			end else if (hi_reg) begin
				ram_we    = 1'b1;
				ram_waddr = store_addr(old_bank, cmd.step_reg);
				ram_wdata = act_rdata;
			end else if (new_bank == BANK_FIQ) begin
				ram_we    = 1'b1;
				ram_waddr = store_addr(BANK_USER, cmd.step_reg);
				ram_wdata = act_rdata;
			end
			// restore side
			if (new_bank == BANK_DUMMY) begin
				pend_d      = 1'b1;
				pend_zero_d = 1'b1;
			end else if (new_bank == BANK_FIQ) begin
				pend_d    = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = store_addr(BANK_FIQ, cmd.step_reg);
			end else if (hi_reg) begin
				pend_d    = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = store_addr(new_bank, cmd.step_reg);
			end else if (old_bank == BANK_FIQ) begin
				pend_d    = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = store_addr(BANK_USER, cmd.step_reg);
			end
		end
	end

	brf_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign res_data = from_ram_q ? ram_rdata : rdata_q;
	assign rd_wide  = {32'b0, res_data};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= mode;
			cmode_q <= cpu_mode;
			reg_q   <= reg_index;
			wval_q  <= wval_wide[DATA_WIDTH-1:0];
		end
		if (cmd.access) begin
			rdata_q    <= act_rdata;
			from_ram_q <= !same_mode;
		end
		if (cmd.finish) begin
			read_data_q   <= (op_q == OP_READ) ? rd_wide[31:0] : 32'd0;
			active_mode_q <= (op_q == OP_SWITCH) ? cmode_q : cur_mode_q;
		end
		pend_zero_s1 <= pend_zero_d;
		pend_idx_s1  <= cmd.step_reg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q  <= MODE_SVC;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < REGS_PER_BANK; i++) begin
				active_q[i] <= '0;
			end
		end else begin
			pend_s1 <= pend_d;
			if (act_we) begin
				active_q[act_widx] <= act_wdata;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (op_q == OP_SWITCH) begin
					cur_mode_q <= cmode_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign active_mode = active_mode_q;

	a_pend_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(cmd.step))
		else $error("restore write without a switch step");

	a_finish_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished beat not presented");

endmodule

[rtl/banked_register_file_mode_switch.sv]
// Top level of the banked register file with processor-mode switching.
// Sixteen active registers plus a 112-word bank store (seven banks of sixteen words, one per
// mode bank) held in a single-port-write, registered-read RAM. After reset the block clears
// the bank store word by word in a clearing pass and holds in_stall high meanwhile. A read or
// write goes from acceptance to result through take, access and present; a mode switch that
// changes the bank also steps r8..r14 one per cycle through the store's one write and
// one read port. The next beat is accepted the cycle after the result is loaded into the
// output register, and that register is loaded only once the previous result has been taken.
module banked_register_file_mode_switch #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [4:0]  cpu_mode,
	input  logic [3:0]  reg_index,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [4:0]  active_mode
);
	import brf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	brf_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.cpu_mode    (cpu_mode),
		.reg_index   (reg_index),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.active_mode (active_mode)
	);

endmodule
